/* rtl/pmpc_pkg.sv */
// ----------------------------------------------------------------------------
// pmpc_pkg
// Shared codes and widths for the presence matrix pair counter.
// ----------------------------------------------------------------------------
package pmpc_pkg;

  // function codes carried in the input item
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_KMER = 2'd1;
  localparam logic [1:0] FUNC_SEQ  = 2'd2;

  // configuration register indexes
  localparam logic REG_NUM_SEQS  = 1'b0;
  localparam logic REG_NUM_KMERS = 1'b1;

  localparam int SEQS_W  = 7;
  localparam int KMERS_W = 11;
  localparam int COUNT_W = 11;
  localparam int WORD_W  = 64;
  localparam int POP_W   = 7;

  function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int k = 0; k < WORD_W; k++) begin
      c = c + POP_W'(v[k]);
    end
    return c;
  endfunction

endpackage

/* rtl/pmpc_ram.sv */
// ----------------------------------------------------------------------------
// pmpc_ram
// Generic RAM, one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module pmpc_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/presence_matrix_pair_counter.sv */
// ----------------------------------------------------------------------------
// presence_matrix_pair_counter
// Presence bit matrix (sequence rows by k-mer columns) with pair queries.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis; tuser carries the function code. A load item
// writes one 64-bit row word into the matrix RAM in the cycle it is accepted
// and gives no result; an unused function code is dropped the same way.
// A k-mer pair query walks the rows in use, one row per cycle through the two
// RAM read ports. A sequence pair query walks the row words, one AND and
// popcount per cycle. A query with an index out of range returns status 1
// and count 0 without reading the matrix.
// One query is worked on at a time; the rate is set by the one word pair the
// RAM delivers per cycle. Results leave through an output register on
// m_axis, so the next item is taken while a result waits; a query that
// finishes while that register is still full waits until it drains.
// Configuration (num_seqs, num_kmers) is written on the cfg channel, which
// is always ready. Reset clears the registers and control state; the matrix
// RAM is not cleared, and every word must be loaded before it is queried.
// ----------------------------------------------------------------------------
module presence_matrix_pair_counter #(
  parameter int MAX_SEQS  = 64,
  parameter int MAX_KMERS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // load_row[5:0], load_word[9:6], load_bits[73:10], first_index[83:74],
  // second_index[93:84], zero fill[95:94]
  input  logic [95:0] s_axis_tdata_i,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pair_count[10:0], zero fill[15:11]
  output logic [15:0] m_axis_tdata_o,
  // status[0]
  output logic        m_axis_tuser_o
);

  localparam int Words  = MAX_KMERS / 64;
  localparam int Depth  = MAX_SEQS * Words;
  localparam int AddrW  = $clog2(Depth);
  localparam int NsW    = $clog2(MAX_SEQS + 1);
  localparam int NkW    = $clog2(MAX_KMERS + 1);
  localparam int CntMax = (MAX_SEQS > Words) ? MAX_SEQS : Words;
  localparam int CntW   = $clog2(CntMax + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  // input fields
  logic [1:0]                  func;
  logic [5:0]                  load_row;
  logic [3:0]                  load_word;
  logic [pmpc_pkg::WORD_W-1:0] load_bits;
  logic [9:0]                  first_index;
  logic [9:0]                  second_index;

  assign func         = s_axis_tuser_i;
  assign load_row     = s_axis_tdata_i[5:0];
  assign load_word    = s_axis_tdata_i[9:6];
  assign load_bits    = s_axis_tdata_i[73:10];
  assign first_index  = s_axis_tdata_i[83:74];
  assign second_index = s_axis_tdata_i[93:84];

  logic [pmpc_pkg::SEQS_W-1:0]  num_seqs_q;
  logic [pmpc_pkg::KMERS_W-1:0] num_kmers_q;

  state_e                        state_q, state_d;
  logic                          kmer_q, kmer_d;
  logic                          err_q, err_d;
  logic [9:0]                    first_q, first_d;
  logic [9:0]                    second_q, second_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]               limit_q, limit_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [CntW-1:0]               rd_word_q, rd_word_d;
  logic                          pop_vld_q, pop_vld_d;
  logic [pmpc_pkg::POP_W-1:0]    pop_q, pop_d;
  logic [pmpc_pkg::COUNT_W-1:0]  acc_q, acc_d;
  logic                          out_valid_q, out_valid_d;
  logic [pmpc_pkg::COUNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic                          out_status_q, out_status_d;

  logic [NsW-1:0]   ns;
  logic [NkW-1:0]   nk;
  logic [CntW-1:0]  nw;
  logic             in_acc;
  logic             issue;
  logic             done;
  logic             out_free;

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [AddrW-1:0]            ram_raddr_a;
  logic [AddrW-1:0]            ram_raddr_b;
  logic [pmpc_pkg::WORD_W-1:0] ram_rdata_a;
  logic [pmpc_pkg::WORD_W-1:0] ram_rdata_b;

  logic [pmpc_pkg::WORD_W-1:0]  mask;
  logic [pmpc_pkg::COUNT_W:0]   acc_sum;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seqs_q  <= '0;
      num_kmers_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pmpc_pkg::REG_NUM_SEQS:  num_seqs_q  <= cfg_data_i[pmpc_pkg::SEQS_W-1:0];
        pmpc_pkg::REG_NUM_KMERS: num_kmers_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp registers to the built matrix size
  assign ns = (32'(num_seqs_q) > MAX_SEQS) ? NsW'(MAX_SEQS) : NsW'(num_seqs_q);
  assign nk = (32'(num_kmers_q) > MAX_KMERS) ? NkW'(MAX_KMERS) : NkW'(num_kmers_q);
  assign nw = CntW'((32'(nk) + 32'd63) >> 6);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // loads write in the accept cycle
  assign ram_we = in_acc && (func == pmpc_pkg::FUNC_LOAD) &&
                  (32'(load_row) < MAX_SEQS) && (32'(load_word) < Words);
  assign ram_waddr = AddrW'(32'(load_row) * Words + 32'(load_word));

  // read addresses for the current walk step
  always_comb begin
    if (kmer_q) begin
      ram_raddr_a = AddrW'(32'(idx_q) * Words + 32'(first_q[9:6]));
      ram_raddr_b = AddrW'(32'(idx_q) * Words + 32'(second_q[9:6]));
    end else begin
      ram_raddr_a = AddrW'(32'(first_q) * Words + 32'(idx_q));
      ram_raddr_b = AddrW'(32'(second_q) * Words + 32'(idx_q));
    end
  end

  pmpc_ram #(
    .Width (pmpc_pkg::WORD_W),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (load_bits),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign issue    = (state_q == S_RUN) && (idx_q < limit_q);
  assign done     = (state_q == S_RUN) && !issue && !rd_vld_q && !pop_vld_q;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // partial last word of a row keeps only the columns in use
  always_comb begin
    if (32'(rd_word_q) == (32'(nk) >> 6)) begin
      mask = (64'd1 << nk[5:0]) - 64'd1;
    end else begin
      mask = '1;
    end
  end

  assign acc_sum = {1'b0, acc_q} + (pmpc_pkg::COUNT_W + 1)'(pop_q);

  always_comb begin
    state_d      = state_q;
    kmer_d       = kmer_q;
    err_d        = err_q;
    first_d      = first_q;
    second_d     = second_q;
    idx_d        = idx_q;
    limit_d      = limit_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q;
    out_cnt_d    = out_cnt_q;
    out_status_d = out_status_q;

    rd_vld_d  = issue;
    rd_word_d = idx_q;
    pop_vld_d = rd_vld_q;
    if (kmer_q) begin
      pop_d = pmpc_pkg::POP_W'(ram_rdata_a[first_q[5:0]] & ram_rdata_b[second_q[5:0]]);
    end else begin
      pop_d = pmpc_pkg::popcount64(ram_rdata_a & ram_rdata_b & mask);
    end

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (func == pmpc_pkg::FUNC_KMER || func == pmpc_pkg::FUNC_SEQ)) begin
          kmer_d   = (func == pmpc_pkg::FUNC_KMER);
          first_d  = first_index;
          second_d = second_index;
          idx_d    = '0;
          acc_d    = '0;
          if (func == pmpc_pkg::FUNC_KMER) begin
            err_d = (32'(first_index) >= 32'(nk)) || (32'(second_index) >= 32'(nk));
            limit_d = err_d ? '0 : CntW'(ns);
          end else begin
            err_d = (32'(first_index) >= 32'(ns)) || (32'(second_index) >= 32'(ns));
            limit_d = err_d ? '0 : nw;
          end
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        if (pop_vld_q) begin
          // saturate at the top of the count field
          acc_d = acc_sum[pmpc_pkg::COUNT_W] ? '1 : acc_sum[pmpc_pkg::COUNT_W-1:0];
        end
        if (done && out_free) begin
          out_valid_d  = 1'b1;
          out_cnt_d    = acc_q;
          out_status_d = err_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      pop_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
      kmer_q      <= 1'b0;
      idx_q       <= '0;
      limit_q     <= '0;
      acc_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      pop_vld_q   <= pop_vld_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
      kmer_q      <= kmer_d;
      idx_q       <= idx_d;
      limit_q     <= limit_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    second_q     <= second_d;
    rd_word_q    <= rd_word_d;
    pop_q        <= pop_d;
    out_cnt_q    <= out_cnt_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_cnt_q};
  assign m_axis_tuser_o  = out_status_q;

  // read data and partial counts only exist inside a running query
  a_rd_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || pop_vld_q) |-> (state_q == S_RUN))
    else $error("matrix read data outside a running query");

  // an out-of-range query never reads the matrix
  a_err_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && err_q) |-> (!rd_vld_q && !pop_vld_q))
    else $error("out-of-range query walked the matrix");

  // a result only appears when a query finishes
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RUN))
    else $error("result item without a finished query");

  // the running count never goes down
  a_acc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && $past(state_q == S_RUN)) |-> (acc_q >= $past(acc_q)))
    else $error("pair count decreased during a walk");

  // the matrix is written only while no query is running
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!rd_vld_q && !pop_vld_q && state_q == S_IDLE))
    else $error("matrix write during a query");

endmodule

/* bench/presence_matrix_pair_counter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_matrix_pair_counter_tb
// Self-checking bench for the presence matrix pair counter.
// ----------------------------------------------------------------------------
// A short table of hand-picked steps runs first: queries straight out of
// reset, an all-ones matrix at the largest sizes, partial last words,
// registers written above their limits and unused function codes. The matrix
// is then refilled with random words and random phases follow, each under its
// own register setting. Each result is checked against a hand-typed value or a
// local bit-matrix model kept in step with the accepted items. Input items come
// in bursts with gaps, and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module presence_matrix_pair_counter_tb;

  localparam int SEQ_ROWS     = 64;
  localparam int ROW_WORDS    = 16;
  localparam int KMER_COLS    = 1024;
  localparam int COUNT_SAT    = 2047;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic       ST_OK       = 1'b0;
  localparam logic       ST_RANGE    = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  load_row;
    logic [3:0]  load_word;
    logic [63:0] load_bits;
    logic [9:0]  idx_a;
    logic [9:0]  idx_b;
  } pm_item_t;

  typedef struct packed {
    logic [10:0] count;
    logic        status;
  } pm_result_t;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_FILL} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    pm_item_t    it;
    logic        typed;
    pm_result_t  exp;
    logic        cfg_idx;
    logic [10:0] cfg_val;
    logic        fill_random;
  } dir_step_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_ready = 1'b1;

  logic        cfg_ready;
  logic        s_ready;
  logic        m_valid;
  logic [15:0] m_tdata;
  logic        m_tuser;

  presence_matrix_pair_counter DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // model state
  logic [63:0] matrix_words [SEQ_ROWS][ROW_WORDS];
  logic [6:0]  cfg_num_seqs = '0;
  logic [10:0] cfg_num_kmers = '0;
  pm_result_t  pending_counts[$];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int n_loads = 0, n_kmer = 0, n_seq = 0, n_unused = 0, n_checked = 0, n_cfg = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_counts.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure, pattern picked anew each time rdy_tick wraps
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  logic [7:0] rdy_tick = '0;
  always @(posedge clk) begin
    rdy_tick <= rdy_tick + 8'd1;
    if (rdy_tick == 8'd255) rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
    case (rdy_mode)
      RDY_ALWAYS:   m_ready <= 1'b1;
      RDY_COIN:     m_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   m_ready <= ($urandom_range(0, 7) == 0);
      default:      m_ready <= (rdy_tick[4:0] < 5'd20);
    endcase
  end

  function automatic int seqs_active();
    return (int'(cfg_num_seqs) > SEQ_ROWS) ? SEQ_ROWS : int'(cfg_num_seqs);
  endfunction

  function automatic int kmers_active();
    return (int'(cfg_num_kmers) > KMER_COLS) ? KMER_COLS : int'(cfg_num_kmers);
  endfunction

  function automatic pm_result_t count_pairs(pm_item_t it);
    int ns, nk, nw, cnt, rem;
    logic [63:0] both;
    pm_result_t res;
    ns = seqs_active();
    nk = kmers_active();
    cnt = 0;
    res.status = ST_OK;
    if (it.func == pmpc_pkg::FUNC_KMER) begin
      if (int'(it.idx_a) >= nk || int'(it.idx_b) >= nk) begin
        res.status = ST_RANGE;
      end else begin
        for (int r = 0; r < ns; r++) begin
          if (matrix_words[r][it.idx_a[9:6]][it.idx_a[5:0]] &&
              matrix_words[r][it.idx_b[9:6]][it.idx_b[5:0]]) cnt++;
        end
      end
    end else begin
      if (int'(it.idx_a) >= ns || int'(it.idx_b) >= ns) begin
        res.status = ST_RANGE;
      end else begin
        nw = (nk + 63) / 64;
        for (int w = 0; w < nw; w++) begin
          both = matrix_words[it.idx_a[5:0]][w] & matrix_words[it.idx_b[5:0]][w];
          rem = nk - w * 64;
          // columns past num_kmers in the last word never count
          if (rem < 64) both &= (64'd1 << rem) - 64'd1;
          cnt += $countones(both);
        end
      end
    end
    if (cnt > COUNT_SAT) cnt = COUNT_SAT;
    res.count = 11'(cnt);
    return res;
  endfunction

  task automatic send_item(input pm_item_t it, input logic typed, input pm_result_t typed_res);
    int gap;
    s_valid <= 1'b1;
    s_tdata <= {2'b00, it.idx_b, it.idx_a, it.load_bits, it.load_word, it.load_row};
    s_tuser <= it.func;
    do @(posedge clk); while (!s_ready);
    case (it.func)
      pmpc_pkg::FUNC_LOAD: begin
        matrix_words[it.load_row][it.load_word] = it.load_bits;
        n_loads++;
      end
      pmpc_pkg::FUNC_KMER, pmpc_pkg::FUNC_SEQ: begin
        pending_counts.push_back(typed ? typed_res : count_pairs(it));
        if (it.func == pmpc_pkg::FUNC_KMER) n_kmer++;
        else n_seq++;
      end
      default: n_unused++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender stops and waits until every query has been answered
  task automatic wait_drain();
    s_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pmpc_pkg::REG_NUM_SEQS) cfg_num_seqs = val[6:0];
    else cfg_num_kmers = val;
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  pm_result_t got_res, want_res;
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      got_res.count  = m_tdata[10:0];
      got_res.status = m_tuser;
      n_checked++;
      if (pending_counts.size() == 0) begin
        note_mismatch("result with no query pending", -1, int'(got_res.count));
      end else begin
        want_res = pending_counts.pop_front();
        if (got_res.count !== want_res.count)
          note_mismatch("pair_count", int'(want_res.count), int'(got_res.count));
        if (got_res.status !== want_res.status)
          note_mismatch("status", int'(want_res.status), int'(got_res.status));
      end
    end
  end

  function automatic pm_item_t noise_item();
    pm_item_t it;
    it.func      = 2'($urandom);
    it.load_row  = 6'($urandom);
    it.load_word = 4'($urandom);
    it.load_bits = {$urandom, $urandom};
    it.idx_a     = 10'($urandom);
    it.idx_b     = 10'($urandom);
    return it;
  endfunction

  function automatic dir_step_t query_step(logic [1:0] func, int a, int b);
    dir_step_t s;
    s = '0;
    s.kind     = STEP_ITEM;
    s.it       = noise_item();
    s.it.func  = func;
    s.it.idx_a = 10'(a);
    s.it.idx_b = 10'(b);
    return s;
  endfunction

  function automatic dir_step_t typed_step(logic [1:0] func, int a, int b, int cnt,
                                           logic st);
    dir_step_t s;
    s = query_step(func, a, b);
    s.typed     = 1'b1;
    s.exp.count = 11'(cnt);
    s.exp.status = st;
    return s;
  endfunction

  function automatic dir_step_t load_step(int row, int word, logic [63:0] bits);
    dir_step_t s;
    s = query_step(pmpc_pkg::FUNC_LOAD, 0, 0);
    s.it.load_row  = 6'(row);
    s.it.load_word = 4'(word);
    s.it.load_bits = bits;
    return s;
  endfunction

  function automatic dir_step_t cfg_step(logic idx, int val);
    dir_step_t s;
    s = '0;
    s.kind    = STEP_CFG;
    s.cfg_idx = idx;
    s.cfg_val = 11'(val);
    return s;
  endfunction

  function automatic dir_step_t fill_step(logic rnd, logic [63:0] bits);
    dir_step_t s;
    s = '0;
    s.kind         = STEP_FILL;
    s.fill_random  = rnd;
    s.it.load_bits = bits;
    return s;
  endfunction

  function automatic pm_item_t random_item();
    pm_item_t it;
    int pick, lim;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 30) it.func = pmpc_pkg::FUNC_LOAD;
    else if (pick < 63) it.func = pmpc_pkg::FUNC_KMER;
    else if (pick < 95) it.func = pmpc_pkg::FUNC_SEQ;
    else it.func = FUNC_UNUSED;
    case ($urandom_range(0, 5))
      0: it.load_bits = '0;
      1: it.load_bits = '1;
      2: it.load_bits &= {$urandom, $urandom};
      default: ;
    endcase
    lim = (it.func == pmpc_pkg::FUNC_KMER) ? kmers_active() : seqs_active();
    // mostly valid indexes so the walk really happens
    if (lim > 0 && $urandom_range(0, 9) < 8) begin
      it.idx_a = 10'($urandom_range(0, lim - 1));
      it.idx_b = 10'($urandom_range(0, lim - 1));
      if ($urandom_range(0, 4) == 0) it.idx_b = it.idx_a;
    end
    return it;
  endfunction

  dir_step_t   dir_steps[$];
  pm_item_t    fill_it;
  pm_item_t    rnd_it;
  int          phase_done;
  logic [10:0] phase_seqs  [PHASES] = '{11'd64,   11'd0, 11'd1, 11'd127,  11'd2047,
                                        11'd2, 11'd0, 11'd0};
  logic [10:0] phase_kmers [PHASES] = '{11'd1024, 11'd0, 11'd1, 11'd2047, 11'd63,
                                        11'd1000, 11'd0, 11'd0};

  initial begin
    // straight out of reset both sizes are zero, so any index is out of range
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 0, 0, 0, ST_RANGE));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_SEQ, 0, 0, 0, ST_RANGE));
    dir_steps.push_back(query_step(FUNC_UNUSED, 1023, 1023));
    dir_steps.push_back(fill_step(1'b0, '1));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_SEQS, 64));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_KMERS, 1024));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 0, 1023, 64, ST_OK));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_SEQ, 0, 63, 1024, ST_OK));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 1023, 1023, 64, ST_OK));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_SEQ, 63, 63, 1024, ST_OK));
    dir_steps.push_back(load_step(0, 0, '0));
    dir_steps.push_back(load_step(63, 15, 64'h8000_0000_0000_0001));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 0, 0, 63, ST_OK));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_SEQ, 0, 63));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_KMER, 1023, 960));
    // partial last word
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_KMERS, 1023));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 1023, 0, 0, ST_RANGE));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_SEQ, 63, 62));
    // registers above their limits clamp to the matrix size
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_SEQS, 127));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_KMERS, 2047));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_KMER, 5, 5));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_SEQ, 1, 2, 1024, ST_OK));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_SEQS, 63));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_SEQ, 63, 0, 0, ST_RANGE));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_SEQ, 62, 0));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_SEQS, 1));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_KMERS, 1));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_KMER, 0, 0));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 1, 0, 0, ST_RANGE));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_SEQ, 0, 0));
    dir_steps.push_back(cfg_step(pmpc_pkg::REG_NUM_KMERS, 65));
    dir_steps.push_back(query_step(pmpc_pkg::FUNC_SEQ, 0, 0));
    dir_steps.push_back(typed_step(pmpc_pkg::FUNC_KMER, 1023, 64, 0, ST_RANGE));
    dir_steps.push_back(fill_step(1'b1, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      case (dir_steps[i].kind)
        STEP_CFG: begin
          wait_drain();
          write_reg(dir_steps[i].cfg_idx, dir_steps[i].cfg_val);
        end
        STEP_FILL: begin
          for (int r = 0; r < SEQ_ROWS; r++) begin
            for (int w = 0; w < ROW_WORDS; w++) begin
              fill_it = noise_item();
              fill_it.func      = pmpc_pkg::FUNC_LOAD;
              fill_it.load_row  = 6'(r);
              fill_it.load_word = 4'(w);
              fill_it.load_bits = dir_steps[i].it.load_bits;
              // random refill mixes sparse, dense and plain words
              if (dir_steps[i].fill_random) begin
                fill_it.load_bits = {$urandom, $urandom};
                case ($urandom_range(0, 2))
                  0: fill_it.load_bits &= {$urandom, $urandom};
                  1: fill_it.load_bits |= {$urandom, $urandom};
                  default: ;
                endcase
              end
              send_item(fill_it, 1'b0, '0);
            end
          end
        end
        default: send_item(dir_steps[i].it, dir_steps[i].typed, dir_steps[i].exp);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      if (p >= PHASES - 2) begin
        phase_seqs[p]  = 11'($urandom_range(0, 2047));
        phase_kmers[p] = 11'($urandom_range(0, 2047));
      end
      write_reg(pmpc_pkg::REG_NUM_SEQS, phase_seqs[p]);
      write_reg(pmpc_pkg::REG_NUM_KMERS, phase_kmers[p]);
      phase_done = 0;
      while (phase_done < PHASE_ITEMS) begin
        rnd_it = random_item();
        send_item(rnd_it, 1'b0, '0);
        if (rnd_it.func != FUNC_UNUSED) phase_done++;
      end
    end

    wait_drain();
    $display("covered %0d loads, %0d k-mer pair and %0d sequence pair queries, %0d dropped",
             n_loads, n_kmer, n_seq, n_unused);
    $display("%0d results checked over %0d register writes, %0d mismatches",
             n_checked, n_cfg, mismatches);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pmpc_pkg.sv
rtl/pmpc_ram.sv
rtl/presence_matrix_pair_counter.sv
bench/presence_matrix_pair_counter_tb.sv
